// ===== src/gll_pkg.sv =====
// ----------------------------------------------------------------------------
// GPGLL time extractor package
// Shared types and constants for the sentence parser and result buffer.
// ----------------------------------------------------------------------------
package gll_pkg;

	localparam logic [7:0]  POS_SAT    = 8'd255;
	localparam logic [7:0]  HDR_LEN    = 8'd5;
	localparam logic [7:0]  CHAR_COMMA = 8'h2C;
	localparam logic [7:0]  CHAR_ZERO  = 8'h30;
	localparam logic [7:0]  CHAR_NINE  = 8'h39;
	localparam logic [2:0]  TIME_FIELD_COMMA = 3'd5;
	localparam logic [2:0]  TIME_CHARS = 3'd6;
	localparam int unsigned STORED_DIGITS = 5;

	localparam logic [1:0] STATUS_EMPTY = 2'd0;
	localparam logic [1:0] STATUS_HALF  = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_SCAN = 2'd1,
		PH_TIME = 2'd2
	} phase_t;

	typedef struct packed {
		logic [1:0] sync_status;
		logic       digits_valid;
		logic [6:0] hours;
		logic [6:0] minutes;
		logic [6:0] seconds;
	} result_t;

	// Expected header character "GPGLL" at header position 0..4.
	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h47;
			3'd1:    ch = 8'h50;
			3'd2:    ch = 8'h47;
			3'd3:    ch = 8'h4C;
			3'd4:    ch = 8'h4C;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [7:0] times10(input logic [3:0] d);
		logic [7:0] w;
		w = {4'b0000, d};
		return 8'((w << 3) + (w << 1));
	endfunction

endpackage

// ===== src/gll_parse.sv =====
// ----------------------------------------------------------------------------
// GPGLL sentence parser
// Header check, comma counting, time field capture and held time update.
// ----------------------------------------------------------------------------
module gll_parse #(
	parameter int MAX_POSITION       = 255,
	parameter int FULL_SYNC_POSITION = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic [7:0]            char_byte,
	input  logic                  sentence_start,
	input  logic signed [4:0]     tz_offset,
	output logic                  res_valid,
	output gll_pkg::result_t      res
);

	gll_pkg::phase_t phase_q, phase_d, phase_e;
	logic [7:0] pos_q, pos_d, pos_e, pos_inc;
	logic [2:0] comma_q, comma_d, comma_e, comma_inc;
	logic [2:0] dcnt_q, dcnt_d, dcnt_e, dcnt_inc;
	logic [1:0] pend_q, pend_d, pend_e;
	logic       flag_q, flag_d, flag_e;
	logic [6:0] hh_q, mm_q, ss_q, hh_d, mm_d, ss_d;
	logic [3:0] digit_q [gll_pkg::STORED_DIGITS];
	logic       store_en;
	logic       is_digit, all_ok;
	logic [6:0] h_raw;
	logic signed [7:0] h_sum, h_wrap;

	assign is_digit = (char_byte >= gll_pkg::CHAR_ZERO) && (char_byte <= gll_pkg::CHAR_NINE);

	// Hour arithmetic from the stored hour digits plus the timezone offset.
	assign h_raw  = 7'(gll_pkg::times10(digit_q[0]) + {4'b0000, digit_q[1]});
	assign h_sum  = $signed({1'b0, h_raw}) + $signed({{3{tz_offset[4]}}, tz_offset});
	always_comb begin
		if (h_sum > 8'sd23) begin
			h_wrap = h_sum - 8'sd24;
		end else if (h_sum < 8'sd0) begin
			h_wrap = h_sum + 8'sd24;
		end else begin
			h_wrap = h_sum;
		end
	end

	always_comb begin
		// A sentence start restarts the parse with this character at position 0.
		phase_e = sentence_start ? gll_pkg::PH_SCAN : phase_q;
		pos_e   = sentence_start ? 8'd0 : pos_q;
		comma_e = sentence_start ? 3'd0 : comma_q;
		dcnt_e  = sentence_start ? 3'd0 : dcnt_q;
		pend_e  = sentence_start ? gll_pkg::STATUS_EMPTY : pend_q;
		flag_e  = sentence_start ? 1'b1 : flag_q;

		pos_inc   = (pos_e < gll_pkg::POS_SAT) ? pos_e + 8'd1 : pos_e;
		comma_inc = comma_e + 3'd1;
		dcnt_inc  = dcnt_e + 3'd1;
		all_ok    = flag_e & is_digit;

		phase_d   = phase_e;
		pos_d     = pos_e;
		comma_d   = comma_e;
		dcnt_d    = dcnt_e;
		pend_d    = pend_e;
		flag_d    = flag_e;
		hh_d      = hh_q;
		mm_d      = mm_q;
		ss_d      = ss_q;
		store_en  = 1'b0;
		res_valid = 1'b0;
		res       = '{sync_status: gll_pkg::STATUS_EMPTY, digits_valid: 1'b0,
		              hours: hh_q, minutes: mm_q, seconds: ss_q};

		case (phase_e)
			gll_pkg::PH_SCAN: begin
				pos_d = pos_inc;
				if (pos_e < gll_pkg::HDR_LEN) begin
					if (char_byte != gll_pkg::hdr_char(pos_e[2:0])) begin
						phase_d = gll_pkg::PH_IDLE;
					end
				end else if (pos_e >= 8'(MAX_POSITION)) begin
					phase_d = gll_pkg::PH_IDLE;
				end else if (char_byte == gll_pkg::CHAR_COMMA) begin
					comma_d = comma_inc;
					if (comma_inc == gll_pkg::TIME_FIELD_COMMA) begin
						pend_d  = (pos_e > 8'(FULL_SYNC_POSITION)) ?
						          gll_pkg::STATUS_FULL : gll_pkg::STATUS_HALF;
						dcnt_d  = 3'd0;
						flag_d  = 1'b1;
						phase_d = gll_pkg::PH_TIME;
					end
				end
			end
			gll_pkg::PH_TIME: begin
				pos_d = pos_inc;
				if (dcnt_e == 3'd0 && char_byte == gll_pkg::CHAR_COMMA) begin
					phase_d   = gll_pkg::PH_IDLE;
					res_valid = 1'b1;
				end else begin
					flag_d   = all_ok;
					store_en = 1'b1;
					dcnt_d   = dcnt_inc;
					if (dcnt_inc == gll_pkg::TIME_CHARS) begin
						phase_d          = gll_pkg::PH_IDLE;
						dcnt_d           = 3'd0;
						res_valid        = 1'b1;
						res.sync_status  = pend_e;
						res.digits_valid = all_ok;
						if (all_ok) begin
							hh_d = h_wrap[6:0];
							mm_d = 7'(gll_pkg::times10(digit_q[2]) + {4'b0000, digit_q[3]});
							ss_d = 7'(gll_pkg::times10(digit_q[4]) + {4'b0000, char_byte[3:0]});
							res.hours   = hh_d;
							res.minutes = mm_d;
							res.seconds = ss_d;
						end
					end
				end
			end
			default: begin
			end
		endcase

		if (!item_valid) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= gll_pkg::PH_IDLE;
			pos_q   <= 8'd0;
			comma_q <= 3'd0;
			dcnt_q  <= 3'd0;
			pend_q  <= gll_pkg::STATUS_EMPTY;
			flag_q  <= 1'b1;
			hh_q    <= 7'd0;
			mm_q    <= 7'd0;
			ss_q    <= 7'd0;
		end else if (item_valid) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			comma_q <= comma_d;
			dcnt_q  <= dcnt_d;
			pend_q  <= pend_d;
			flag_q  <= flag_d;
			hh_q    <= hh_d;
			mm_q    <= mm_d;
			ss_q    <= ss_d;
		end
	end

	// Digit store has no reset; the last time character is used directly.
	always_ff @(posedge clk) begin
		for (int k = 0; k < gll_pkg::STORED_DIGITS; k++) begin
			if (item_valid && store_en && dcnt_e == 3'(k)) begin
				digit_q[k] <= char_byte[3:0];
			end
		end
	end

endmodule

// ===== src/gll_rbuf.sv =====
// ----------------------------------------------------------------------------
// GPGLL result buffer
// Two-entry result queue that drives the output channel.
// ----------------------------------------------------------------------------
module gll_rbuf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gll_pkg::result_t  push_data,
	output logic              out_valid,
	input  logic              out_ready,
	output gll_pkg::result_t  head,
	output logic [1:0]        count
);

	gll_pkg::result_t head_q, tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid & out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign head      = head_q;
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if ((cnt_q == 2'd0 || (cnt_q == 2'd1 && pop)) && push) begin
			head_q <= push_data;
		end else if (pop && cnt_q == 2'd2) begin
			head_q <= tail_q;
		end
		if (push && ((cnt_q == 2'd1 && !pop) || (cnt_q == 2'd2 && pop))) begin
			tail_q <= push_data;
		end
	end

endmodule

// ===== src/nmea_gll_time_extractor.sv =====
// ----------------------------------------------------------------------------
// NMEA GPGLL time extractor
// Parses GPGLL sentence characters and reports the UTC time field, shifted
// by a programmable timezone offset.
// ----------------------------------------------------------------------------
//  Channel  Handshake             Payload
//  input    in_valid / in_ready   char_byte, sentence_start
//  output   out_valid / out_ready sync_status, digits_valid, hours, minutes, seconds
//  config   cfg_we                cfg_wdata (timezone offset, signed hours)
//
// One character is taken per cycle while in_ready is high. A character is
// registered, parsed in the next cycle, and its result is then pushed into a
// two-entry result buffer. in_ready drops only when the buffer together with
// the character being parsed would exceed two entries.
// Reset clears the parser to idle, the held time to zero and the offset to 0.
// ----------------------------------------------------------------------------
module nmea_gll_time_extractor #(
	parameter int MAX_POSITION       = 255,
	parameter int FULL_SYNC_POSITION = 20
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_byte,
	input  logic       sentence_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] sync_status,
	output logic       digits_valid,
	output logic [6:0] hours,
	output logic [6:0] minutes,
	output logic [6:0] seconds,
	input  logic       cfg_we,
	input  logic [4:0] cfg_wdata
);

	logic signed [4:0] tz_q;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              start_s1;
	logic              res_valid;
	gll_pkg::result_t  res, head;
	logic [1:0]        count;
	logic [1:0]        occ;
	logic              pop;

	assign pop      = out_valid & out_ready;
	assign occ      = 2'(count + {1'b0, valid_s1});
	assign in_ready = (occ < 2'd2) || (occ == 2'd2 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tz_q     <= 5'sd0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				tz_q <= $signed(cfg_wdata);
			end
			valid_s1 <= in_valid & in_ready;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1  <= char_byte;
			start_s1 <= sentence_start;
		end
	end

	gll_parse #(
		.MAX_POSITION       (MAX_POSITION),
		.FULL_SYNC_POSITION (FULL_SYNC_POSITION)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (valid_s1),
		.char_byte      (char_s1),
		.sentence_start (start_s1),
		.tz_offset      (tz_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	gll_rbuf u_rbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.count     (count)
	);

	assign sync_status  = head.sync_status;
	assign digits_valid = head.digits_valid;
	assign hours        = head.hours;
	assign minutes      = head.minutes;
	assign seconds      = head.seconds;

	// The buffer plus the character in flight never exceed two results.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(count) + 32'(valid_s1)) <= 32'd2)
		else $error("result buffer overflow");

	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted character not registered");

	a_digits_need_time: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && digits_valid) |-> (sync_status != gll_pkg::STATUS_EMPTY))
		else $error("valid digits reported with an empty time field");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sync_status != 2'd3))
		else $error("undefined sync status");

endmodule
